// ===== rtl/tansd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the tANS table decoder.
package tansd_pkg;

  localparam int TABLE_SIZE_DEF   = 256;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam logic [3:0] LOG2_MIN   = 4'd1;
  localparam logic [3:0] LOG2_MAX   = 4'd8;
  localparam logic [3:0] LOG2_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_SET_COUNT = 2'd0,
    OP_SPREAD    = 2'd1,
    OP_START     = 2'd2,
    OP_DECODE    = 2'd3
  } op_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  // One decode table slot: symbol, bit count, base of the next state.
  typedef struct packed {
    logic [7:0] symbol;
    logic [3:0] nb;
    logic [8:0] newx;
  } entry_t;

  // Input word as held in the input register.
  typedef struct packed {
    op_t        op;
    logic [7:0] symbol;
    logic [8:0] count;
    logic [7:0] orig;
    logic [7:0] init;
    logic [7:0] win;
  } item_t;

  // floor(log2 x), zero for x of 0 or 1.
  function automatic logic [3:0] msb_pos(input logic [9:0] x);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (x[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/tans_table_decoder.sv =====
`timescale 1ns / 1ps
// tANS decoder with on-chip decode table build, single-pass datapath.
// Datapath: input register, then result register; a stalled result channel holds both.
// Throughput: one word per cycle while out_ready does not stall; the decode table is prefetched
//   every cycle at the next state, so back-to-back decode steps run without a bubble.
// Reset (rst, synchronous): clears valids, fill slot, states; table_log2 returns to 8.
// Symbol counters and decode table are not cleared; they hold data once written.
module tans_table_decoder #(
  parameter int TABLE_SIZE   = tansd_pkg::TABLE_SIZE_DEF,
  parameter int SYMBOL_COUNT = tansd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: table_log2
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] symbol,
  input  logic [8:0] count,
  input  logic [7:0] original_state,
  input  logic [7:0] initial_state,
  input  logic [7:0] stream_bits,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] decoded_symbol,
  output logic [3:0] bits_consumed,
  output logic [7:0] next_state,
  output logic       back_at_start
);

  localparam int TIDX_W = $clog2(TABLE_SIZE);
  localparam int SIDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // ---------------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------------
  logic [9:0]         cnt_mem [SYMBOL_COUNT];  // per-symbol next counter
  tansd_pkg::entry_t  tbl_mem [TABLE_SIZE];    // decode table

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  tansd_pkg::item_t   s1;
  logic [9:0]         cnt_rd;      // counter of s1.symbol, read at accept
  tansd_pkg::entry_t  entry_rd;    // table slot of cur_state, refreshed each cycle
  logic [8:0]         fill_slot;
  logic [7:0]         cur_state;
  logic [7:0]         start_state;
  logic [3:0]         table_log2;

  logic [8:0]         fill_slot_next;
  logic [7:0]         cur_state_next;
  logic [7:0]         start_state_next;

  // ---------------------------------------------------------------------------
  // Handshake: s1 drains into the result register when it is free or being taken
  // ---------------------------------------------------------------------------
  logic s1_go;
  logic in_fire;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Table size in use: R clamped to 1..8, L = 2^R
  // ---------------------------------------------------------------------------
  logic [3:0] r_eff;
  logic [8:0] l_size;

  always_comb begin
    if (table_log2 < tansd_pkg::LOG2_MIN) begin
      r_eff = tansd_pkg::LOG2_MIN;
    end else if (table_log2 > tansd_pkg::LOG2_MAX) begin
      r_eff = tansd_pkg::LOG2_MAX;
    end else begin
      r_eff = table_log2;
    end
  end

  assign l_size = 9'd1 << r_eff;

  // ---------------------------------------------------------------------------
  // Spread path (op 1): x from the counter, nb = R - floor(log2 x), newX = (x << nb) - L
  // ---------------------------------------------------------------------------
  logic              sym_ok;
  logic              not_full;
  logic [9:0]        x_val;
  logic [3:0]        x_msb;
  logic [3:0]        nb_new;
  logic [8:0]        newx;
  tansd_pkg::entry_t spread_entry;

  assign sym_ok   = int'(s1.symbol) < SYMBOL_COUNT;
  assign not_full = (fill_slot < l_size) && (int'(fill_slot) < TABLE_SIZE);
  assign x_val    = sym_ok ? cnt_rd : 10'd0;
  assign x_msb    = tansd_pkg::msb_pos(x_val);
  // saturates to 0 when x is larger than the table
  assign nb_new   = (x_msb <= r_eff) ? (r_eff - x_msb) : 4'd0;
  assign newx     = (x_val[8:0] << nb_new) - l_size;

  always_comb begin
    spread_entry.symbol = s1.symbol;
    spread_entry.nb     = nb_new;
    spread_entry.newx   = newx;
  end

  // counter write: op 0 seeds, op 1 bumps
  logic              cnt_we;
  logic [SIDX_W-1:0] cnt_waddr;
  logic [9:0]        cnt_wdata;

  assign cnt_we    = s1_go && sym_ok &&
                     ((s1.op == tansd_pkg::OP_SET_COUNT) ||
                      ((s1.op == tansd_pkg::OP_SPREAD) && not_full));
  assign cnt_waddr = SIDX_W'(s1.symbol);
  assign cnt_wdata = (s1.op == tansd_pkg::OP_SET_COUNT) ? {1'b0, s1.count} : (x_val + 10'd1);

  // table write at the fill slot
  logic              tbl_we;
  logic [TIDX_W-1:0] tbl_waddr;

  assign tbl_we    = s1_go && (s1.op == tansd_pkg::OP_SPREAD) && not_full;
  assign tbl_waddr = TIDX_W'(fill_slot);

  // ---------------------------------------------------------------------------
  // Decode path (op 3): state = newX + top nb bits of the R-bit window
  // ---------------------------------------------------------------------------
  logic [3:0] nb_dec;
  logic [7:0] win_masked;
  logic [7:0] win_bits;
  logic [7:0] dec_state;

  assign nb_dec     = (entry_rd.nb > tansd_pkg::LOG2_MAX) ? tansd_pkg::LOG2_MAX : entry_rd.nb;
  assign win_masked = s1.win & 8'(l_size - 9'd1);

  always_comb begin
    if (nb_dec == 4'd0) begin
      win_bits = 8'd0;
    end else if (nb_dec <= r_eff) begin
      win_bits = win_masked >> (r_eff - nb_dec);
    end else begin
      // slot built under a larger R: zeros fill below the window
      win_bits = win_masked << (nb_dec - r_eff);
    end
  end

  assign dec_state = entry_rd.newx[7:0] + win_bits;

  // ---------------------------------------------------------------------------
  // State updates
  // ---------------------------------------------------------------------------
  always_comb begin
    fill_slot_next   = fill_slot;
    cur_state_next   = cur_state;
    start_state_next = start_state;
    if (s1_go) begin
      case (s1.op)
        tansd_pkg::OP_SET_COUNT: begin
          fill_slot_next = 9'd0;
        end
        tansd_pkg::OP_SPREAD: begin
          if (not_full) begin
            fill_slot_next = fill_slot + 9'd1;
          end
        end
        tansd_pkg::OP_START: begin
          start_state_next = s1.orig;
          cur_state_next   = s1.init;
        end
        tansd_pkg::OP_DECODE: begin
          cur_state_next = dec_state;
        end
        default: begin
          fill_slot_next = fill_slot;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_slot   <= 9'd0;
      cur_state   <= 8'd0;
      start_state <= 8'd0;
      table_log2  <= tansd_pkg::LOG2_RESET;
    end else begin
      fill_slot   <= fill_slot_next;
      cur_state   <= cur_state_next;
      start_state <= start_state_next;
      if (cfg_we) begin
        table_log2 <= cfg_wdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register; counter read issued at accept, with bypass of the write in flight
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.op     <= tansd_pkg::op_t'(op);
      s1.symbol <= symbol;
      s1.count  <= count;
      s1.orig   <= original_state;
      s1.init   <= initial_state;
      s1.win    <= stream_bits;
      if (cnt_we && (cnt_waddr == SIDX_W'(symbol))) begin
        cnt_rd <= cnt_wdata;
      end else begin
        cnt_rd <= cnt_mem[SIDX_W'(symbol)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode table: write at fill slot, read every cycle at the upcoming state
  // so entry_rd always mirrors the slot of cur_state (slot 0 under reset).
  // ---------------------------------------------------------------------------
  logic [TIDX_W-1:0] tbl_raddr;

  assign tbl_raddr = rst ? '0 : TIDX_W'(cur_state_next);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= spread_entry;
    end
    if (tbl_we && (tbl_waddr == tbl_raddr)) begin
      entry_rd <= spread_entry;
    end else begin
      entry_rd <= tbl_mem[tbl_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1.op == tansd_pkg::OP_DECODE) begin
        kind           <= tansd_pkg::KIND_SYMBOL;
        decoded_symbol <= entry_rd.symbol;
        bits_consumed  <= nb_dec;
      end else begin
        kind           <= tansd_pkg::KIND_ACK;
        decoded_symbol <= 8'd0;
        bits_consumed  <= 4'd0;
      end
      next_state    <= cur_state_next;
      back_at_start <= (cur_state_next == start_state_next);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_needs_drain: assert property (@(posedge clk) disable iff (rst)
    in_fire && s1_valid |-> s1_go)
    else $error("input word taken while input register is stuck");

  a_ack_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == tansd_pkg::KIND_ACK) |-> (decoded_symbol == 8'd0) &&
    (bits_consumed == 4'd0))
    else $error("acknowledge word carries decode data");

  a_nb_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bits_consumed <= tansd_pkg::LOG2_MAX)
    else $error("bits consumed above 8");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_slot <= 9'd256)
    else $error("fill slot past the largest table");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1.op == tansd_pkg::OP_START) |=>
    (cur_state == $past(s1.init)) && (start_state == $past(s1.orig)))
    else $error("start word did not load states");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid && (next_state == cur_state))
    else $error("result state does not match decoder state");

endmodule

// ===== tb/tans_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the tANS table decoder, predicts each result word and compares.
module tans_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] symbol,
  input  logic [8:0] count,
  input  logic [7:0] original_state,
  input  logic [7:0] initial_state,
  input  logic [7:0] stream_bits,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       kind,
  input  logic [7:0] decoded_symbol,
  input  logic [3:0] bits_consumed,
  input  logic [7:0] next_state,
  input  logic       back_at_start,
  output int         fail_count,
  output int         words_in,
  output int         words_out
);
  import tansd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
    logic [3:0] nb;
    logic [7:0] state;
    logic       home;
  } decode_result_t;

  // Shadow of the block's state.
  logic [9:0] next_cnt [SYMBOL_COUNT_DEF];
  entry_t     dec_table [TABLE_SIZE_DEF];
  logic [8:0] fill_pos;
  logic [7:0] state_now;
  logic [7:0] home_state;
  logic [3:0] log2_reg;

  decode_result_t awaited_results [$];
  decode_result_t want;
  decode_result_t got;
  item_t          word;

  initial begin
    fail_count = 0;
    words_in   = 0;
    words_out  = 0;
  end

  function automatic int top_bit(input logic [9:0] v);
    int p;
    p = 0;
    while (v > 1) begin
      v = v >> 1;
      p++;
    end
    return p;
  endfunction

  // Applies one input word to the shadow state and returns the word it should produce.
  function automatic decode_result_t tans_step(input item_t w);
    decode_result_t e;
    int r, l, x, p, nb, nx, wbits, bits;
    entry_t slot;
    r = (log2_reg < LOG2_MIN) ? 1 : (log2_reg > LOG2_MAX) ? 8 : int'(log2_reg);
    l = 1 << r;
    e = '0;
    case (w.op)
      OP_SET_COUNT: begin
        next_cnt[w.symbol] = {1'b0, w.count};
        fill_pos = '0;
      end
      OP_SPREAD: begin
        if (fill_pos < l && fill_pos < TABLE_SIZE_DEF) begin
          x = int'(next_cnt[w.symbol]);
          next_cnt[w.symbol] = 10'(x + 1);
          p = top_bit(10'(x));
          nb = (p <= r) ? r - p : 0;
          nx = ((x << nb) - l) & 'h1FF;
          slot.symbol = w.symbol;
          slot.nb     = 4'(nb);
          slot.newx   = 9'(nx);
          dec_table[fill_pos[7:0]] = slot;
          fill_pos = 9'(fill_pos + 1);
        end
      end
      OP_START: begin
        home_state = w.orig;
        state_now  = w.init;
      end
      OP_DECODE: begin
        slot = dec_table[state_now];
        nb = int'(slot.nb);
        if (nb > 8) nb = 8;
        wbits = int'(w.win) & (l - 1);
        if (nb == 0) bits = 0;
        else if (nb <= r) bits = wbits >> (r - nb);
        else bits = wbits << (nb - r);
        state_now = 8'(int'(slot.newx) + bits);
        e.kind   = KIND_SYMBOL;
        e.symbol = slot.symbol;
        e.nb     = 4'(nb);
      end
    endcase
    e.state = state_now;
    e.home  = (state_now == home_state);
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_pos   = '0;
      state_now  = '0;
      home_state = '0;
      log2_reg   = LOG2_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) log2_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        word.op     = op_t'(op);
        word.symbol = symbol;
        word.count  = count;
        word.orig   = original_state;
        word.init   = initial_state;
        word.win    = stream_bits;
        awaited_results.push_back(tans_step(word));
        words_in <= words_in + 1;
      end
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        got.kind   = kind;
        got.symbol = decoded_symbol;
        got.nb     = bits_consumed;
        got.state  = next_state;
        got.home   = back_at_start;
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with none awaited: kind %0d sym %0d nb %0d state %0d",
                     $realtime, got.kind, got.symbol, got.nb, got.state);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display({"%0t: result differs (exp/got): kind %0d/%0d sym %0d/%0d nb %0d/%0d",
                        " state %0d/%0d home %0d/%0d"}, $realtime, want.kind, got.kind,
                       want.symbol, got.symbol, want.nb, got.nb, want.state, got.state,
                       want.home, got.home);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the tANS table decoder testbench: clock, reset, stimulus, receiver and verdict.
module tb;
  import tansd_pkg::*;

  localparam int ITEMS        = 1150;
  localparam int STALL_CYCLES = 60;        // long receiver hold-off, fills the pipe
  localparam longint LIMIT_NS = 2_000_000; // far beyond the slowest correct run

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = '0;
  logic [7:0] symbol = '0;
  logic [8:0] count = '0;
  logic [7:0] original_state = '0;
  logic [7:0] initial_state = '0;
  logic [7:0] stream_bits = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] decoded_symbol;
  logic [3:0] bits_consumed;
  logic [7:0] next_state;
  logic       back_at_start;

  int fail_count;
  int words_in;
  int words_out;

  // Stimulus bookkeeping.
  int words_sent = 0;
  bit quiet = 1'b0;               // no idling on either side while set
  bit have_count [SYMBOL_COUNT_DEF];  // symbols whose next counter was loaded
  int stall_asks = 0;
  int stall_taken = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  tans_table_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .symbol        (symbol),
    .count         (count),
    .original_state(original_state),
    .initial_state (initial_state),
    .stream_bits   (stream_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .decoded_symbol(decoded_symbol),
    .bits_consumed (bits_consumed),
    .next_state    (next_state),
    .back_at_start (back_at_start)
  );

  tans_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .symbol        (symbol),
    .count         (count),
    .original_state(original_state),
    .initial_state (initial_state),
    .stream_bits   (stream_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .decoded_symbol(decoded_symbol),
    .bits_consumed (bits_consumed),
    .next_state    (next_state),
    .back_at_start (back_at_start),
    .fail_count    (fail_count),
    .words_in      (words_in),
    .words_out     (words_out)
  );

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_taken != stall_asks) begin
      out_ready   <= 1'b0;
      stall_taken <= stall_asks;
      stall_left  <= STALL_CYCLES;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // Every field random; callers overwrite the ones the op uses.
  function automatic item_t rand_word(input op_t o);
    item_t w;
    w.op     = o;
    w.symbol = 8'($urandom_range(0, 255));
    w.count  = 9'($urandom_range(0, 256));
    w.orig   = 8'($urandom_range(0, 255));
    w.init   = 8'($urandom_range(0, 255));
    w.win    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Offer one word and hold it until taken. Called right after a rising edge;
  // returns on the edge that accepted the word, with in_valid still high.
  task automatic send_word(input item_t w);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    op             <= w.op;
    symbol         <= w.symbol;
    count          <= w.count;
    original_state <= w.orig;
    initial_state  <= w.init;
    stream_bits    <= w.win;
    do @(posedge clk); while (!in_ready);
    if (w.op == OP_SET_COUNT) have_count[w.symbol] = 1'b1;
    words_sent++;
  endtask

  // Directed shorthand: op 0 (symbol, count), op 1 (symbol), op 2 (orig, init), op 3 (window).
  task automatic poke(input op_t o, input int a, input int b);
    item_t w;
    w = rand_word(o);
    case (o)
      OP_SET_COUNT: begin w.symbol = 8'(a); w.count = 9'(b); end
      OP_SPREAD:    w.symbol = 8'(a);
      OP_START:     begin w.orig = 8'(a); w.init = 8'(b); end
      OP_DECODE:    w.win = 8'(a);
    endcase
    send_word(w);
  endtask

  // Drop valid and wait until every issued word has its result back.
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in != words_out);
  endtask

  task automatic set_log2(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Load counts for a handful of symbols and spread the table.
  // tidy: counts sum to L and each symbol fills exactly its count of slots,
  // so decoding from a state below L stays below L. Otherwise counts and
  // spread are arbitrary and the table may under- or over-fill.
  task automatic build_table(input int r, input bit tidy);
    int l, nsym, k, j, t;
    int syms [$];
    int cnts [$];
    int order [$];
    bit used [256];
    item_t w;
    l = 1 << r;
    used = '{default: 1'b0};
    nsym = $urandom_range(1, (l < 12) ? l : 12);
    while (syms.size() < nsym) begin
      k = $urandom_range(0, 255);
      if (!used[k]) begin
        used[k] = 1'b1;
        syms.push_back(k);
        cnts.push_back(tidy ? 1 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 256)
                                                                 : $urandom_range(0, l)));
      end
    end
    if (tidy) begin
      repeat (l - nsym) begin
        k = $urandom_range(0, nsym - 1);
        cnts[k] = cnts[k] + 1;
      end
    end
    foreach (syms[i]) begin
      w = rand_word(OP_SET_COUNT);
      w.symbol = 8'(syms[i]);
      w.count  = 9'(cnts[i]);
      send_word(w);
    end
    if (tidy) begin
      foreach (syms[i]) repeat (cnts[i]) order.push_back(syms[i]);
      // shuffle the spread
      for (k = order.size() - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
      // now and then one more slot than the table holds
      if ($urandom_range(0, 3) == 0) order.push_back(syms[$urandom_range(0, nsym - 1)]);
    end else begin
      repeat ($urandom_range((l > 1) ? l / 2 : 1, l + 3))
        order.push_back(syms[$urandom_range(0, nsym - 1)]);
    end
    foreach (order[n]) begin
      w = rand_word(OP_SPREAD);
      w.symbol = 8'(order[n]);
      send_word(w);
    end
  endtask

  // One message: load states, then a run of decode steps with a little noise.
  // Only used once every table slot has been written, so any state is safe.
  task automatic decode_run(input int l);
    item_t w;
    w = rand_word(OP_START);
    if ($urandom_range(0, 3) != 0) begin
      w.orig = 8'($urandom_range(0, l - 1));
      w.init = 8'($urandom_range(0, l - 1));
    end
    send_word(w);
    repeat ($urandom_range(1, 16)) begin
      if ($urandom_range(0, 99) < 6) begin
        w = rand_word(op_t'($urandom_range(0, 3)));
        // a spread must hit a counter that was loaded at some point
        if (w.op == OP_SPREAD)
          while (!have_count[w.symbol]) w.symbol = 8'($urandom_range(0, 255));
        send_word(w);
      end
      send_word(rand_word(OP_DECODE));
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("tans_table_decoder: mismatch");
    $finish;
  end

  initial begin
    int phase;
    int r;
    logic [3:0] v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // state load under the reset table size
    poke(OP_START, 255, 0);
    wait_drained;
    set_log2(4'd2);
    // counts at both extremes, then a 4-slot table for symbols 7, 200, 0 and 255
    poke(OP_SET_COUNT, 7, 0);
    poke(OP_SET_COUNT, 200, 256);
    poke(OP_SET_COUNT, 0, 1);
    poke(OP_SET_COUNT, 255, 3);
    // slot 0: zero x gives nb = R and a wrapped base
    // slot 1: x of 256 saturates nb to 0
    poke(OP_SPREAD, 7, 0);
    poke(OP_SPREAD, 200, 0);
    poke(OP_SPREAD, 0, 0);
    poke(OP_SPREAD, 255, 0);
    // table already full: acknowledged, nothing written
    poke(OP_SPREAD, 255, 0);
    // Decode stays on slots 2 and 3; slots 0 and 1 would lead to slots
    // never written yet.
    poke(OP_START, 0, 2);
    poke(OP_DECODE, 8'hFF, 0);
    poke(OP_DECODE, 8'h00, 0);
    poke(OP_DECODE, 8'h02, 0);
    poke(OP_DECODE, 8'hFF, 0);
    poke(OP_DECODE, 8'hFE, 0);
    poke(OP_DECODE, 8'h55, 0);
    // return to the start state
    poke(OP_START, 2, 3);
    poke(OP_DECODE, 8'h00, 0);

    // ---- random phases ----
    // Phase 0 fills all 256 slots under R = 8, so every later state is safe.
    // Phase 2 carries the long receiver hold-off; phases 3 and 4 run with no idling.
    phase = 0;
    while (words_sent < ITEMS) begin
      wait_drained;
      if (phase == 0) begin
        v = LOG2_MAX;
      end else begin
        case ($urandom_range(0, 9))
          0: v = 4'd0;
          1: v = 4'd15;
          2: v = LOG2_MAX;
          3: v = LOG2_MIN;
          default: v = 4'($urandom_range(2, 7));
        endcase
      end
      set_log2(v);
      r = (v < LOG2_MIN) ? 1 : (v > LOG2_MAX) ? 8 : int'(v);
      quiet <= (phase == 3 || phase == 4);
      // skipping the build leaves a table from an earlier size in use
      if (phase == 0)
        build_table(r, 1'b1);
      else if ($urandom_range(0, 9) < ((r >= 7) ? 3 : 7))
        build_table(r, $urandom_range(0, 9) != 0);
      if (phase == 2) stall_asks <= stall_asks + 1;
      repeat ((phase == 3 || phase == 4) ? 12 : $urandom_range(1, 4)) decode_run(1 << r);
      phase++;
    end

    wait_drained;
    repeat (8) @(posedge clk);
    if (fail_count == 0 && words_in == words_out)
      $display("tans_table_decoder: match");
    else
      $display("tans_table_decoder: mismatch");
    $finish;
  end

endmodule
